[sv/grid_keyframe_vertex_interpolator_unit_macros.svh]
// Assertion macros shared by the keyframe interpolator RTL.
`ifndef GRID_KEYFRAME_VERTEX_INTERPOLATOR_UNIT_MACROS_SVH
`define GRID_KEYFRAME_VERTEX_INTERPOLATOR_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define GKVI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gkvi assertion failed");

// Check cons in the cycle after ante.
`define GKVI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gkvi assertion failed");

`endif

[sv/gkvi_pkg.sv]
// Types and constants of the keyframe vertex interpolator.
package gkvi_pkg;

   localparam int TIME_REGS  = 5;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TIME_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TIME_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TIME_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TIME_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TIME_4 = 3'd5;

   typedef enum logic [0:0] {
      OP_STORE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_EVAL    = 2'd0,
      ST_NO_KEYS = 2'd1,
      ST_RANGE   = 2'd2,
      ST_STORED  = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [31:0]        color;
   } vertex_type;

   typedef struct packed {
      status_type status;
      logic [2:0] seg;
      logic       interp;
   } ctrl_type;

   typedef struct packed {
      ctrl_type   ctrl;
      vertex_type vtx;
   } result_type;

endpackage

[sv/gkvi_req_if.sv]
// Request channel: store or evaluate items.
interface gkvi_req_if;
   logic               valid;
   logic               ready;
   logic [0:0]         opcode;
   logic [2:0]         key_slot;
   logic [6:0]         vertex_index;
   logic signed [31:0] query_time;
   logic signed [31:0] in_pos_x;
   logic signed [31:0] in_pos_y;
   logic signed [31:0] in_pos_z;
   logic [31:0]        in_color;

   modport source (output valid, opcode, key_slot, vertex_index, query_time,
                   in_pos_x, in_pos_y, in_pos_z, in_color, input ready);
   modport sink   (input valid, opcode, key_slot, vertex_index, query_time,
                   in_pos_x, in_pos_y, in_pos_z, in_color, output ready);
endinterface

[sv/gkvi_rsp_if.sv]
// Response channel: one result item per request item.
interface gkvi_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [2:0]         segment_index;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic [31:0]        out_color;

   modport source (output valid, status, segment_index, out_pos_x, out_pos_y,
                   out_pos_z, out_color, input ready);
   modport sink   (input valid, status, segment_index, out_pos_x, out_pos_y,
                   out_pos_z, out_color, output ready);
endinterface

[sv/gkvi_ram.sv]
// Generic synchronous RAM, one write port, one registered read port.
module gkvi_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[sv/gkvi_divider.sv]
// Pipelined restoring divider for the Q0.16 segment ratio, one bit a stage.
module gkvi_divider #(
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [31:0]      in_dividend,
   input  logic [31:0]      in_divisor,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [gkvi_pkg::FRAC_W-1:0] out_quot,
   output logic [TAG_W-1:0] out_tag
);
   localparam int STEPS = gkvi_pkg::FRAC_W;

   logic                valid_ff [0:STEPS];
   logic [31:0]         rem_ff   [0:STEPS];
   logic [31:0]         div_ff   [0:STEPS];
   logic [STEPS-1:0]    quot_ff  [0:STEPS];
   logic [TAG_W-1:0]    tag_ff   [0:STEPS];
   logic [31:0]         rem_in   [0:STEPS-1];
   logic [STEPS-1:0]    quot_in  [0:STEPS-1];

   // Dividend stays below divisor, so the remainder fits 32 bits.
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [32:0] shifted;
      logic        take;
      logic [32:0] diff;
      always_comb begin
         shifted    = {rem_ff[j], 1'b0};
         take       = shifted >= {1'b0, div_ff[j]};
         diff       = shifted - {1'b0, div_ff[j]};
         rem_in[j]  = take ? diff[31:0] : shifted[31:0];
         quot_in[j] = {quot_ff[j][STEPS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= STEPS; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 0; j < STEPS; j++) begin
            valid_ff[j+1] <= valid_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_dividend;
         div_ff[0]  <= in_divisor;
         quot_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
         for (int j = 0; j < STEPS; j++) begin
            rem_ff[j+1]  <= rem_in[j];
            div_ff[j+1]  <= div_ff[j];
            quot_ff[j+1] <= quot_in[j];
            tag_ff[j+1]  <= tag_ff[j];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_quot  = quot_ff[STEPS];
   assign out_tag   = tag_ff[STEPS];
endmodule

[sv/gkvi_lerp.sv]
// Interpolation datapath: difference times ratio, then round and add.
module gkvi_lerp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  gkvi_pkg::ctrl_type     in_ctrl,
   input  logic                   in_a_odd,
   input  logic [gkvi_pkg::FRAC_W-1:0] in_ratio,
   input  logic [127:0]           even_data,
   input  logic [127:0]           odd_data,
   output logic                   out_valid,
   output gkvi_pkg::result_type   out_result
);
   // Stage M: control aligned with the RAM read data.
   logic                          m_valid_ff;
   gkvi_pkg::ctrl_type            m_ctrl_ff;
   logic                          m_a_odd_ff;
   logic [gkvi_pkg::FRAC_W-1:0]   m_ratio_ff;

   // Stage X: products and base values.
   logic                          x_valid_ff;
   gkvi_pkg::ctrl_type            x_ctrl_ff;
   gkvi_pkg::vertex_type          x_base_ff;
   logic signed [49:0]            x_prod_ff [0:2];
   logic signed [25:0]            x_cprod_ff [0:3];

   gkvi_pkg::vertex_type          va;
   gkvi_pkg::vertex_type          vb;
   logic signed [16:0]            ratio_s;
   logic signed [32:0]            dpos [0:2];
   logic signed [8:0]             dcol [0:3];
   logic signed [49:0]            x_prod_in [0:2];
   logic signed [25:0]            x_cprod_in [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         x_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= in_valid;
         x_valid_ff <= m_valid_ff;
      end
   end

   always_comb begin
      va = m_a_odd_ff ? gkvi_pkg::vertex_type'(odd_data) : gkvi_pkg::vertex_type'(even_data);
      vb = m_a_odd_ff ? gkvi_pkg::vertex_type'(even_data) : gkvi_pkg::vertex_type'(odd_data);
      // Clamped results use one key only: keep the other bank out of the sum.
      if (!m_ctrl_ff.interp) begin
         vb = va;
      end
      ratio_s = $signed({1'b0, m_ratio_ff});
      dpos[0] = {vb.x[31], vb.x} - {va.x[31], va.x};
      dpos[1] = {vb.y[31], vb.y} - {va.y[31], va.y};
      dpos[2] = {vb.z[31], vb.z} - {va.z[31], va.z};
      for (int c = 0; c < 4; c++) begin
         dcol[c] = $signed({1'b0, vb.color[8*c +: 8]}) - $signed({1'b0, va.color[8*c +: 8]});
         x_cprod_in[c] = dcol[c] * ratio_s;
      end
      for (int p = 0; p < 3; p++) begin
         x_prod_in[p] = dpos[p] * ratio_s;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ctrl_ff  <= in_ctrl;
         m_a_odd_ff <= in_a_odd;
         m_ratio_ff <= in_ratio;
         x_ctrl_ff  <= m_ctrl_ff;
         x_base_ff  <= va;
         for (int p = 0; p < 3; p++) begin
            x_prod_ff[p] <= x_prod_in[p];
         end
         for (int c = 0; c < 4; c++) begin
            x_cprod_ff[c] <= x_cprod_in[c];
         end
      end
   end

   // Round half up; the result lies between the two keys, so it wraps back in range.
   logic signed [49:0] psum [0:2];
   logic signed [25:0] csum [0:3];
   always_comb begin
      for (int p = 0; p < 3; p++) begin
         psum[p] = x_prod_ff[p] + 50'sd32768;
      end
      for (int c = 0; c < 4; c++) begin
         csum[c] = x_cprod_ff[c] + 26'sd32768;
      end
      out_result.ctrl  = x_ctrl_ff;
      out_result.vtx.x = x_base_ff.x + $signed(psum[0][47:16]);
      out_result.vtx.y = x_base_ff.y + $signed(psum[1][47:16]);
      out_result.vtx.z = x_base_ff.z + $signed(psum[2][47:16]);
      for (int c = 0; c < 4; c++) begin
         out_result.vtx.color[8*c +: 8] = x_base_ff.color[8*c +: 8] + csum[c][23:16];
      end
      if (x_ctrl_ff.status != gkvi_pkg::ST_EVAL) begin
         out_result.vtx = '0;
      end
   end

   assign out_valid = x_valid_ff;
endmodule

[sv/grid_keyframe_vertex_interpolator_unit.sv]
// Top level of the keyframe vertex interpolator: decode, divider, memories, lerp.
// Pipeline: divider input register, 16 divider stages, memory read, multiply stage,
//   output register.
// Throughput: one item per cycle while the skid is empty; the pipeline and both key banks then
// accept an item every cycle. A skid register takes one more item while a response waits.
// Reset clears key count, key times and all valid bits; vertex memories stay undefined.
module grid_keyframe_vertex_interpolator_unit #(
   parameter int MAX_KEYS  = 5,
   parameter int MAX_VERTS = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   gkvi_req_if.sink                          req_chan,
   gkvi_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [gkvi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gkvi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   `include "grid_keyframe_vertex_interpolator_unit_macros.svh"

   // Keys are split into even and odd banks so both keys of a segment read at once.
   localparam int ROWS       = MAX_KEYS / 2 + 1;
   localparam int BANK_DEPTH = ROWS * MAX_VERTS;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int KEY_LIM    = (MAX_KEYS < gkvi_pkg::TIME_REGS) ? MAX_KEYS : gkvi_pkg::TIME_REGS;
   localparam int TR         = gkvi_pkg::TIME_REGS;

   typedef struct packed {
      logic                 wr;
      logic                 wr_odd;
      logic                 a_odd;
      logic [AW-1:0]        addr_even;
      logic [AW-1:0]        addr_odd;
      gkvi_pkg::ctrl_type   ctrl;
      gkvi_pkg::vertex_type wdata;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   function automatic logic [AW-1:0] vaddr(input logic [3:0] key, input logic [6:0] vi);
      vaddr = AW'(int'(key >> 1) * MAX_VERTS + int'(vi));
   endfunction

   // Configuration registers.
   logic [2:0]         key_count_ff;
   logic signed [31:0] key_time_ff [0:TR-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         for (int i = 0; i < TR; i++) begin
            key_time_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            gkvi_pkg::REG_KEY_COUNT:  key_count_ff   <= csr_wdata[2:0];
            gkvi_pkg::REG_KEY_TIME_0: key_time_ff[0] <= $signed(csr_wdata);
            gkvi_pkg::REG_KEY_TIME_1: key_time_ff[1] <= $signed(csr_wdata);
            gkvi_pkg::REG_KEY_TIME_2: key_time_ff[2] <= $signed(csr_wdata);
            gkvi_pkg::REG_KEY_TIME_3: key_time_ff[3] <= $signed(csr_wdata);
            gkvi_pkg::REG_KEY_TIME_4: key_time_ff[4] <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Output register and skid.
   logic                 out_valid_ff;
   gkvi_pkg::result_type out_data_ff;
   logic                 skid_valid_ff;
   gkvi_pkg::result_type skid_data_ff;
   logic                 advance;
   logic                 accept;

   assign advance        = !skid_valid_ff;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // Decode: segment search, status, addresses, ratio operands.
   logic [2:0]         n_eff;
   logic [TR-1:0]      lt;
   logic [2:0]         pos;
   logic               found;
   logic               last_lt;
   logic [2:0]         key_sel;
   logic               interp;
   logic signed [31:0] kt_lo;
   logic signed [31:0] kt_hi;
   logic [32:0]        diff33;
   logic [32:0]        span33;
   logic [31:0]        dividend;
   logic [31:0]        divisor;
   tag_type            tag_in;
   logic [3:0]         key_a;
   logic [3:0]         key_b;

   always_comb begin
      n_eff = key_count_ff;
      if (int'(key_count_ff) > KEY_LIM) begin
         n_eff = 3'(KEY_LIM);
      end
      for (int i = 0; i < TR; i++) begin
         lt[i] = req_chan.query_time < key_time_ff[i];
      end
      // First key above the query time gives the segment start.
      pos   = '0;
      found = 1'b0;
      for (int i = 1; i < TR; i++) begin
         if (!found && i < int'(n_eff) && lt[i]) begin
            pos   = 3'(i - 1);
            found = 1'b1;
         end
      end
      last_lt = 1'b0;
      for (int i = 0; i < TR; i++) begin
         if (i == int'(n_eff) - 1) begin
            last_lt = lt[i];
         end
      end
      key_sel = '0;
      interp  = 1'b0;
      if (n_eff == 3'd1 || lt[0]) begin
         key_sel = '0;
      end else if (!last_lt) begin
         key_sel = n_eff - 3'd1;
      end else begin
         key_sel = pos;
         interp  = 1'b1;
      end
      kt_lo = '0;
      kt_hi = '0;
      for (int i = 0; i < TR; i++) begin
         if (i == int'(key_sel)) begin
            kt_lo = key_time_ff[i];
         end
         if (i == int'(key_sel) + 1) begin
            kt_hi = key_time_ff[i];
         end
      end
      diff33 = {req_chan.query_time[31], req_chan.query_time} - {kt_lo[31], kt_lo};
      span33 = {kt_hi[31], kt_hi} - {kt_lo[31], kt_lo};
      dividend = 32'd0;
      divisor  = 32'd1;
      if (interp) begin
         dividend = diff33[31:0];
         divisor  = span33[31:0];
      end

      tag_in             = '0;
      tag_in.wdata.x     = req_chan.in_pos_x;
      tag_in.wdata.y     = req_chan.in_pos_y;
      tag_in.wdata.z     = req_chan.in_pos_z;
      tag_in.wdata.color = req_chan.in_color;
      key_a = '0;
      key_b = '0;
      if (req_chan.opcode == gkvi_pkg::OP_STORE) begin
         if (int'(req_chan.key_slot) >= MAX_KEYS || int'(req_chan.vertex_index) >= MAX_VERTS) begin
            tag_in.ctrl.status = gkvi_pkg::ST_RANGE;
         end else begin
            tag_in.ctrl.status = gkvi_pkg::ST_STORED;
            tag_in.wr          = 1'b1;
            tag_in.wr_odd      = req_chan.key_slot[0];
            key_a              = {1'b0, req_chan.key_slot};
            key_b              = {1'b0, req_chan.key_slot};
         end
      end else if (n_eff == 3'd0) begin
         tag_in.ctrl.status = gkvi_pkg::ST_NO_KEYS;
      end else if (int'(req_chan.vertex_index) >= MAX_VERTS) begin
         tag_in.ctrl.status = gkvi_pkg::ST_RANGE;
      end else begin
         tag_in.ctrl.status = gkvi_pkg::ST_EVAL;
         tag_in.ctrl.seg    = key_sel;
         tag_in.ctrl.interp = interp;
         tag_in.a_odd       = key_sel[0];
         key_a              = {1'b0, key_sel};
         key_b              = {1'b0, key_sel} + 4'd1;
      end
      // Even bank address from whichever key is even, odd bank likewise.
      tag_in.addr_even = key_a[0] ? vaddr(key_b, req_chan.vertex_index)
                                  : vaddr(key_a, req_chan.vertex_index);
      tag_in.addr_odd  = key_a[0] ? vaddr(key_a, req_chan.vertex_index)
                                  : vaddr(key_b, req_chan.vertex_index);
   end

   // Ratio divider; every item rides along so stores stay in order with reads.
   logic                         dv_valid;
   logic [gkvi_pkg::FRAC_W-1:0]  dv_quot;
   logic [TAG_W-1:0]             dv_tag_bits;
   tag_type                      dv_tag;

   gkvi_divider #(.TAG_W(TAG_W)) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .in_valid    (accept),
      .in_dividend (dividend),
      .in_divisor  (divisor),
      .in_tag      (tag_in),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_tag     (dv_tag_bits)
   );

   assign dv_tag = tag_type'(dv_tag_bits);

   // Key banks: write stores and read evaluations at the same pipeline point.
   logic [127:0] even_rdata;
   logic [127:0] odd_rdata;
   logic         we_even;
   logic         we_odd;

   assign we_even = advance && dv_valid && dv_tag.wr && !dv_tag.wr_odd;
   assign we_odd  = advance && dv_valid && dv_tag.wr && dv_tag.wr_odd;

   gkvi_ram #(.WIDTH(128), .DEPTH(BANK_DEPTH)) u_bank_even (
      .clock (clock),
      .we    (we_even),
      .waddr (dv_tag.addr_even),
      .wdata (dv_tag.wdata),
      .re    (advance),
      .raddr (dv_tag.addr_even),
      .rdata (even_rdata)
   );

   gkvi_ram #(.WIDTH(128), .DEPTH(BANK_DEPTH)) u_bank_odd (
      .clock (clock),
      .we    (we_odd),
      .waddr (dv_tag.addr_odd),
      .wdata (dv_tag.wdata),
      .re    (advance),
      .raddr (dv_tag.addr_odd),
      .rdata (odd_rdata)
   );

   logic                 lp_valid;
   gkvi_pkg::result_type lp_result;

   gkvi_lerp u_lerp (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (dv_valid),
      .in_ctrl    (dv_tag.ctrl),
      .in_a_odd   (dv_tag.a_odd),
      .in_ratio   (dv_quot),
      .even_data  (even_rdata),
      .odd_data   (odd_rdata),
      .out_valid  (lp_valid),
      .out_result (lp_result)
   );

   // Hold the response until taken; park one extra item in the skid.
   logic out_take;
   assign out_take = out_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= lp_valid;
      end else if (lp_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_data_ff <= lp_result;
      end else if (lp_valid) begin
         skid_data_ff <= lp_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_data_ff.ctrl.status;
   assign rsp_chan.segment_index = out_data_ff.ctrl.seg;
   assign rsp_chan.out_pos_x     = out_data_ff.vtx.x;
   assign rsp_chan.out_pos_y     = out_data_ff.vtx.y;
   assign rsp_chan.out_pos_z     = out_data_ff.vtx.z;
   assign rsp_chan.out_color     = out_data_ff.vtx.color;

   `GKVI_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `GKVI_ASSERT_NEXT(a_out_holds, clock, reset, out_valid_ff && !rsp_chan.ready,
                     out_valid_ff && $stable(out_data_ff))
   `GKVI_ASSERT_SAME(a_non_eval_zero, clock, reset,
                     out_valid_ff && out_data_ff.ctrl.status != gkvi_pkg::ST_EVAL,
                     out_data_ff.ctrl.seg == 3'd0 && out_data_ff.vtx == '0)
endmodule

[sim/grid_keyframe_vertex_interpolator_unit_tb.sv]
// Testbench of the keyframe vertex interpolator: directed table, random phases, self-check.
module grid_keyframe_vertex_interpolator_unit_tb;

   localparam int MAX_KEYS     = 5;
   localparam int MAX_VERTS    = 100;
   localparam int PIPE_DRAIN   = 30;    // longer than the pipeline latency
   localparam int STALL_LIMIT  = 4000;  // cycles without any handshake
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int PHASE_ITEMS  = 80;
   localparam int FILL_VERTS   = 25;

   typedef struct {
      gkvi_pkg::opcode_type op;
      logic [2:0]           slot;
      logic [6:0]           vi;
      logic signed [31:0]   t;
      gkvi_pkg::vertex_type v;
   } job_type;

   typedef struct {
      gkvi_pkg::status_type status;
      logic [2:0]           seg;
      gkvi_pkg::vertex_type vtx;
   } answer_type;

   typedef struct {
      bit                   is_csr;
      logic [2:0]           idx;
      logic [31:0]          data;
      job_type              job;
      bit                   typed;
      gkvi_pkg::status_type st;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [gkvi_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gkvi_pkg::CSR_DATA_W-1:0] csr_wdata;

   gkvi_req_if req_bus ();
   gkvi_rsp_if rsp_bus ();

   grid_keyframe_vertex_interpolator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block: key store, which entries hold data, registers.
   gkvi_pkg::vertex_type key_vtx [MAX_KEYS][MAX_VERTS];
   bit         written [MAX_KEYS][MAX_VERTS];
   logic [2:0] key_count_q;
   longint     key_time_q [5];

   answer_type answers_due [$];
   row_type    directed_rows [$];
   int         errors;
   int         idle_cycles;
   bit         hold_req;
   bit         burst_mode;

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- prediction
   function automatic logic [31:0] lerp_pos(longint a, longint b, longint r);
      longint s;
      s = a * (65536 - r) + b * r + 32768;
      s = s >>> 16;
      return s[31:0];
   endfunction

   function automatic logic [31:0] lerp_color(logic [31:0] a, logic [31:0] b, longint r);
      logic [31:0] res;
      longint      c;
      res = '0;
      for (int ch = 0; ch < 4; ch++) begin
         c = longint'(a[ch*8 +: 8]) * (65536 - r) + longint'(b[ch*8 +: 8]) * r + 32768;
         c = c >> 16;
         res[ch*8 +: 8] = c[7:0];
      end
      return res;
   endfunction

   // Work out the answer to one accepted item; a store also updates the shadow store.
   function automatic answer_type evaluate_item(job_type j);
      answer_type           a;
      int                   n;
      int                   pos;
      longint               t, span, d, r;
      gkvi_pkg::vertex_type lo, hi;
      a.status = gkvi_pkg::ST_EVAL;
      a.seg = '0;
      a.vtx = '0;
      if (j.op == gkvi_pkg::OP_STORE) begin
         if (j.slot >= MAX_KEYS || j.vi >= MAX_VERTS) begin
            a.status = gkvi_pkg::ST_RANGE;
         end else begin
            key_vtx[j.slot][j.vi] = j.v;
            written[j.slot][j.vi] = 1'b1;
            a.status = gkvi_pkg::ST_STORED;
         end
         return a;
      end
      n = (key_count_q > MAX_KEYS) ? MAX_KEYS : int'(key_count_q);
      if (n == 0) begin
         a.status = gkvi_pkg::ST_NO_KEYS;
         return a;
      end
      if (j.vi >= MAX_VERTS) begin
         a.status = gkvi_pkg::ST_RANGE;
         return a;
      end
      t = longint'(j.t);
      if (n == 1 || t < key_time_q[0]) begin
         a.vtx = key_vtx[0][j.vi];
         return a;
      end
      if (t >= key_time_q[n-1]) begin
         a.seg = 3'(n - 1);
         a.vtx = key_vtx[n-1][j.vi];
         return a;
      end
      pos = n - 2;
      for (int i = 1; i < n; i++) begin
         if (t < key_time_q[i]) begin
            pos = i - 1;
            break;
         end
      end
      span = key_time_q[pos+1] - key_time_q[pos];
      d = t - key_time_q[pos];
      if (span <= 0 || d < 0) begin
         r = 0;
      end else begin
         r = (d <<< 16) / span;
         if (r > 65535) r = 65535;
      end
      lo = key_vtx[pos][j.vi];
      hi = key_vtx[pos+1][j.vi];
      a.seg = 3'(pos);
      a.vtx.x = lerp_pos(longint'(lo.x), longint'(hi.x), r);
      a.vtx.y = lerp_pos(longint'(lo.y), longint'(hi.y), r);
      a.vtx.z = lerp_pos(longint'(lo.z), longint'(hi.z), r);
      a.vtx.color = lerp_color(lo.color, hi.color, r);
      return a;
   endfunction

   // ---------------------------------------------------------------- table rows
   function automatic row_type item_row(gkvi_pkg::opcode_type op, int slot, int vi,
                                        longint t, longint x, longint y, longint z,
                                        longint c, bit typed, gkvi_pkg::status_type st);
      row_type row;
      row.is_csr = 1'b0;
      row.idx = '0;
      row.data = '0;
      row.job.op = op;
      row.job.slot = 3'(slot);
      row.job.vi = 7'(vi);
      row.job.t = t[31:0];
      row.job.v.x = x[31:0];
      row.job.v.y = y[31:0];
      row.job.v.z = z[31:0];
      row.job.v.color = c[31:0];
      row.typed = typed;
      row.st = st;
      return row;
   endfunction

   function automatic row_type csr_row(logic [2:0] idx, longint data);
      row_type row;
      row = item_row(gkvi_pkg::OP_STORE, 0, 0, 0, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL);
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data[31:0];
      return row;
   endfunction

   // Append one row at the end of the directed table.
   function automatic void add_row(row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // Sample results and watch for a hang at the rising edge.
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected result, status", 32'(rsp_bus.status), 32'h0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
               if (rsp_bus.segment_index !== want.seg)
                  report_mismatch("segment_index", 32'(rsp_bus.segment_index), 32'(want.seg));
               if (rsp_bus.out_pos_x !== want.vtx.x)
                  report_mismatch("out_pos_x", rsp_bus.out_pos_x, want.vtx.x);
               if (rsp_bus.out_pos_y !== want.vtx.y)
                  report_mismatch("out_pos_y", rsp_bus.out_pos_y, want.vtx.y);
               if (rsp_bus.out_pos_z !== want.vtx.z)
                  report_mismatch("out_pos_z", rsp_bus.out_pos_z, want.vtx.z);
               if (rsp_bus.out_color !== want.vtx.color)
                  report_mismatch("out_color", rsp_bus.out_color, want.vtx.color);
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // Stall the result channel at random; on request, hold off for a long stretch
   // so the pipeline fills up and back-pressures the request side.
   initial begin
      int hold_left;
      int stall_left;
      int pick;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (burst_mode || pick < 60)
               stall_left = 0;
            else if (pick < 92)
               stall_left = $urandom_range(1, 3);
            else if (pick < 98)
               stall_left = $urandom_range(4, 15);
            else
               stall_left = $urandom_range(20, 60);
            rsp_bus.ready <= (stall_left == 0);
         end
      end
   end

   // ---------------------------------------------------------------- sender
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (burst_mode || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item, hold it until accepted, then queue its answer.
   task automatic send_item(job_type j, bit typed, gkvi_pkg::status_type st);
      answer_type a;
      int         gap;
      @(negedge clock);
      req_bus.opcode       <= j.op;
      req_bus.key_slot     <= j.slot;
      req_bus.vertex_index <= j.vi;
      req_bus.query_time   <= j.t;
      req_bus.in_pos_x     <= j.v.x;
      req_bus.in_pos_y     <= j.v.y;
      req_bus.in_pos_z     <= j.v.z;
      req_bus.in_color     <= j.v.color;
      req_bus.valid        <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      a = evaluate_item(j);
      if (typed) begin
         // typed rows carry only a status; every other field is zero
         a.status = st;
         a.seg = '0;
         a.vtx = '0;
      end
      answers_due.insert(answers_due.size(), a);
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (answers_due.size() != 0) @(posedge clock);
      // let the block settle before touching registers
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // Write one register with the block idle and mirror it in the shadow copy.
   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == gkvi_pkg::REG_KEY_COUNT)
         key_count_q = data[2:0];
      else
         key_time_q[idx - 1] = longint'($signed(data));
   endtask

   // Pick a vertex that every key in use has stored, so no empty entry is read.
   function automatic logic [6:0] pick_vertex();
      int  n;
      int  vi;
      bit  ok;
      n = (key_count_q > MAX_KEYS) ? MAX_KEYS : int'(key_count_q);
      if (n == 0) n = 1;
      for (int tries = 0; tries < 16; tries++) begin
         vi = $urandom_range(0, MAX_VERTS - 1);
         ok = 1'b1;
         for (int k = 0; k < n; k++)
            if (!written[k][vi]) ok = 1'b0;
         if (ok) return 7'(vi);
      end
      return 7'd0;
   endfunction

   function automatic logic [31:0] pick_time();
      int     pick;
      longint t;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         t = key_time_q[$urandom_range(0, 4)] + longint'($urandom_range(0, 8)) - 4;
      else if (pick < 7)
         t = key_time_q[$urandom_range(0, 4)] + longint'($urandom_range(0, 131072)) - 65536;
      else if (pick == 7)
         t = longint'($urandom);
      else if (pick == 8)
         t = 64'h8000_0000;
      else
         t = 64'h7FFF_FFFF;
      return t[31:0];
   endfunction

   function automatic job_type random_job();
      job_type j;
      j.slot = 3'($urandom_range(0, 7));
      j.t = $urandom;
      j.v.x = $urandom;
      j.v.y = $urandom;
      j.v.z = $urandom;
      j.v.color = $urandom;
      if ($urandom_range(0, 99) < 25) begin
         j.op = gkvi_pkg::OP_STORE;
         j.slot = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
         j.vi = ($urandom_range(0, 99) < 92) ? 7'($urandom_range(0, 99)) :
                                                7'($urandom_range(100, 127));
      end else begin
         j.op = gkvi_pkg::OP_EVAL;
         j.vi = ($urandom_range(0, 99) < 93) ? pick_vertex() : 7'($urandom_range(100, 127));
         j.t = pick_time();
      end
      return j;
   endfunction

   // Load the five key time registers in one of several shapes.
   task automatic load_key_times(int shape);
      longint t;
      longint base;
      base = longint'($signed($urandom)) >>> 1;
      t = base;
      for (int k = 0; k < 5; k++) begin
         case (shape)
            0: begin
               // ascending, random spacing
               t = t + longint'($urandom_range(1, 1 << 20));
            end
            1: begin
               // spread across the whole range, both extremes included
               t = -64'sd2147483648 + (longint'(k) * 64'sd4294967295) / 4;
            end
            2: begin
               // all keys at one time
               t = base;
            end
            default: begin
               // arbitrary order
               t = longint'($signed($urandom));
            end
         endcase
         write_reg(3'(gkvi_pkg::REG_KEY_TIME_0 + k), t[31:0]);
      end
   endtask

   // ---------------------------------------------------------------- main flow
   initial begin
      job_type j;
      int      counts [10];
      counts = '{5, 5, 1, 2, 3, 4, 0, 6, 7, 5};
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = gkvi_pkg::OP_STORE;
      req_bus.key_slot = '0;
      req_bus.vertex_index = '0;
      req_bus.query_time = '0;
      req_bus.in_pos_x = '0;
      req_bus.in_pos_y = '0;
      req_bus.in_pos_z = '0;
      req_bus.in_color = '0;
      rsp_bus.ready = 1'b0;
      errors = 0;
      idle_cycles = 0;
      hold_req = 1'b0;
      burst_mode = 1'b0;
      key_count_q = '0;
      for (int k = 0; k < 5; k++) key_time_q[k] = 0;
      for (int k = 0; k < MAX_KEYS; k++)
         for (int v = 0; v < MAX_VERTS; v++) begin
            key_vtx[k][v] = '0;
            written[k][v] = 1'b0;
         end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Registers are at reset: no keys yet.
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 1'b1, gkvi_pkg::ST_NO_KEYS));
      add_row(item_row(gkvi_pkg::OP_EVAL, 7, 127, 64'h7FFF_FFFF, -1, -1, -1,
                       64'hFFFF_FFFF, 1'b1, gkvi_pkg::ST_NO_KEYS));
      add_row(item_row(gkvi_pkg::OP_STORE, 0, 0, 0, 64'h7FFF_FFFF, 64'h8000_0000, 0,
                       64'hFFFF_FFFF, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 4, 99, -1, 64'h8000_0000, 64'h7FFF_FFFF, -1,
                       0, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 5, 0, 0, 1, 1, 1, 1, 1'b1, gkvi_pkg::ST_RANGE));
      add_row(item_row(gkvi_pkg::OP_STORE, 7, 127, 0, 1, 1, 1, 1, 1'b1, gkvi_pkg::ST_RANGE));
      add_row(item_row(gkvi_pkg::OP_STORE, 0, 100, 0, 1, 1, 1, 1, 1'b1, gkvi_pkg::ST_RANGE));
      add_row(item_row(gkvi_pkg::OP_STORE, 1, 0, 0, 64'h8000_0000, 64'h7FFF_FFFF,
                       64'h0001_0000, 64'h00FF_00FF, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 2, 0, 0, 0, 0, 0, 64'h8040_20FF,
                       1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 3, 0, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                       64'h8000_0000, 0, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 4, 0, 0, -5, 5, 64'h1234_5678,
                       64'hFF00_FF00, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 0, 99, 0, 3, -3, 0, 64'h0102_0304,
                       1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 1, 99, 0, 64'h8000_0000, 0, 7,
                       64'hFFFF_FFFF, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 2, 99, 0, 64'h7FFF_FFFF, 9, 0,
                       64'h7F7F_7F7F, 1'b1, gkvi_pkg::ST_STORED));
      add_row(item_row(gkvi_pkg::OP_STORE, 3, 99, 0, 0, 64'h8000_0000, 1,
                       64'h8080_8080, 1'b1, gkvi_pkg::ST_STORED));
      // Five keys spanning the full time range.
      add_row(csr_row(gkvi_pkg::REG_KEY_COUNT, 5));
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_0, 64'h8000_0000));
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_1, -1000));
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_2, 0));
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_3, 1000));
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_4, 64'h7FFF_FFFF));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 0, 64'h8000_0000, 0, 0, 0, 0,
                       1'b0, gkvi_pkg::ST_EVAL));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 99, 64'h7FFF_FFFF, 0, 0, 0, 0,
                       1'b0, gkvi_pkg::ST_EVAL));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 0, -500, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 99, 999, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 100, 0, 0, 0, 0, 0, 1'b1, gkvi_pkg::ST_RANGE));
      // Key count above the number of time registers saturates to five.
      add_row(csr_row(gkvi_pkg::REG_KEY_COUNT, 7));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 0, 1, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL));
      // Single key, and a time before the first key.
      add_row(csr_row(gkvi_pkg::REG_KEY_COUNT, 1));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 99, 500, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL));
      add_row(csr_row(gkvi_pkg::REG_KEY_COUNT, 3));
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_0, -10));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 0, -11, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL));
      // Unordered keys: key 1 earlier than key 0.
      add_row(csr_row(gkvi_pkg::REG_KEY_TIME_1, -5000));
      add_row(item_row(gkvi_pkg::OP_EVAL, 0, 0, -9, 0, 0, 0, 0, 1'b0, gkvi_pkg::ST_EVAL));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_reg(directed_rows[i].idx, directed_rows[i].data);
         else
            send_item(directed_rows[i].job, directed_rows[i].typed, directed_rows[i].st);
      end

      // Fill the low vertices of every key back to back so evaluates find data.
      burst_mode = 1'b1;
      for (int v = 0; v < FILL_VERTS; v++)
         for (int k = 0; k < MAX_KEYS; k++) begin
            j = random_job();
            j.op = gkvi_pkg::OP_STORE;
            j.slot = 3'(k);
            j.vi = 7'(v);
            send_item(j, 1'b0, gkvi_pkg::ST_EVAL);
         end

      // Random phases: each one reprograms every register with the block idle.
      for (int ph = 0; ph < 10; ph++) begin
         burst_mode = (ph % 3 == 2);
         write_reg(gkvi_pkg::REG_KEY_COUNT, 32'(counts[ph]));
         load_key_times(ph % 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the result side off once, well into a busy phase
            if (ph == 1 && n == 10) hold_req = 1'b1;
            send_item(random_job(), 1'b0, gkvi_pkg::ST_EVAL);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_drained();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
